[rtl/core/ptzp_pkg.sv]
package ptzp_pkg;

  localparam logic [7:0] SYNC_B0  = 8'hFF;
  localparam logic [7:0] SYNC_B1  = 8'h01;
  localparam logic [7:0] SYNC_B2  = 8'h00;
  localparam logic [7:0] CMD_PAN  = 8'h59;
  localparam logic [7:0] CMD_TILT = 8'h5B;

  // Position units: hundredths of a degree.
  localparam int unsigned CENTIDEG_PER_DEG = 100;

  localparam logic [1:0] ST_PAN    = 2'd0;
  localparam logic [1:0] ST_TILT   = 2'd1;
  localparam logic [1:0] ST_OTHER  = 2'd2;
  localparam logic [1:0] ST_BADSUM = 2'd3;

  // Body byte positions after the sync.
  localparam logic [1:0] BODY_CMD  = 2'd0;
  localparam logic [1:0] BODY_DH   = 2'd1;
  localparam logic [1:0] BODY_DL   = 2'd2;
  localparam logic [1:0] BODY_SUM  = 2'd3;

  typedef struct packed {
    logic        has_result;
    logic [1:0]  status;
    logic [15:0] pan;
    logic [15:0] tilt;
  } parse_res_t;

endpackage

[rtl/core/ptzp_parse_core.sv]
module ptzp_parse_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  output ptzp_pkg::parse_res_t  res
);

  logic [15:0] hist_r, hist_nxt;
  logic        sync_r, sync_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  dh_r, dh_nxt;
  logic [7:0]  dl_r, dl_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] pan_r, pan_nxt;
  logic [15:0] tilt_r, tilt_nxt;
  logic [15:0] value;
  logic [1:0]  status;

  assign value = {dh_r, dl_r};

  always_comb begin
    priority if (rx_byte != sum_r) begin
      status = ptzp_pkg::ST_BADSUM;
    end else if (cmd_r == ptzp_pkg::CMD_PAN) begin
      status = ptzp_pkg::ST_PAN;
    end else if (cmd_r == ptzp_pkg::CMD_TILT) begin
      status = ptzp_pkg::ST_TILT;
    end else begin
      status = ptzp_pkg::ST_OTHER;
    end
  end

  always_comb begin
    hist_nxt = hist_r;
    sync_nxt = sync_r;
    cnt_nxt  = cnt_r;
    cmd_nxt  = cmd_r;
    dh_nxt   = dh_r;
    dl_nxt   = dl_r;
    sum_nxt  = sum_r;
    pan_nxt  = pan_r;
    tilt_nxt = tilt_r;
    if (!sync_r) begin
      if (hist_r == {ptzp_pkg::SYNC_B0, ptzp_pkg::SYNC_B1} &&
          rx_byte == ptzp_pkg::SYNC_B2) begin
        sync_nxt = 1'b1;
        cnt_nxt  = ptzp_pkg::BODY_CMD;
        sum_nxt  = ptzp_pkg::SYNC_B1 + ptzp_pkg::SYNC_B2;
        hist_nxt = '0;
      end else begin
        hist_nxt = {hist_r[7:0], rx_byte};
      end
    end else begin
      unique case (cnt_r)
        ptzp_pkg::BODY_CMD: begin
          cmd_nxt = rx_byte;
          sum_nxt = sum_r + rx_byte;
          cnt_nxt = ptzp_pkg::BODY_DH;
        end
        ptzp_pkg::BODY_DH: begin
          dh_nxt  = rx_byte;
          sum_nxt = sum_r + rx_byte;
          cnt_nxt = ptzp_pkg::BODY_DL;
        end
        ptzp_pkg::BODY_DL: begin
          dl_nxt  = rx_byte;
          sum_nxt = sum_r + rx_byte;
          cnt_nxt = ptzp_pkg::BODY_SUM;
        end
        default: begin
          if (status == ptzp_pkg::ST_PAN) begin
            pan_nxt = value;
          end
          if (status == ptzp_pkg::ST_TILT) begin
            tilt_nxt = value;
          end
          sync_nxt = 1'b0;
          cnt_nxt  = ptzp_pkg::BODY_CMD;
          hist_nxt = '0;
        end
      endcase
    end
  end

  always_comb begin
    res.has_result = sync_r && (cnt_r == ptzp_pkg::BODY_SUM);
    res.status     = status;
    res.pan        = pan_nxt;
    res.tilt       = tilt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      sync_r <= 1'b0;
      cnt_r  <= ptzp_pkg::BODY_CMD;
      cmd_r  <= '0;
      dh_r   <= '0;
      dl_r   <= '0;
      sum_r  <= '0;
      pan_r  <= '0;
      tilt_r <= '0;
    end else if (step) begin
      hist_r <= hist_nxt;
      sync_r <= sync_nxt;
      cnt_r  <= cnt_nxt;
      cmd_r  <= cmd_nxt;
      dh_r   <= dh_nxt;
      dl_r   <= dl_nxt;
      sum_r  <= sum_nxt;
      pan_r  <= pan_nxt;
      tilt_r <= tilt_nxt;
    end
  end

endmodule

[rtl/core/ptz_position_reply_parser.sv]
// Parses received serial bytes for pan/tilt position reply frames (sync FF 01 00, command,
// two data bytes, checksum). One item is one byte; each completed 7-byte frame gives one
// result with its status and the stored pan and tilt positions in hundredths of a degree.
// An accepted byte is held in the input register, then passes through the parser into the result
// register; one byte is taken every cycle while in_stall is low. in_stall rises only when
// the result register is full, stalled, and the byte in the input register would complete a
// frame.
module ptz_position_reply_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_status,
  output logic [15:0] out_pan_centideg,
  output logic [15:0] out_tilt_centideg
);

  logic                 in_vld_r;
  logic [7:0]           in_byte_r;
  logic                 out_free;
  logic                 advance;
  ptzp_pkg::parse_res_t res;
  logic                 out_vld_r;
  logic [1:0]           status_r;
  logic [15:0]          pan_r;
  logic [15:0]          tilt_r;

  ptzp_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  assign out_free = !out_vld_r || !out_stall;
  // A byte that completes no frame never waits for the result register.
  assign advance  = in_vld_r && (!res.has_result || out_free);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= advance && res.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && res.has_result) begin
      status_r <= res.status;
      pan_r    <= res.pan;
      tilt_r   <= res.tilt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_frame_status  = status_r;
  assign out_pan_centideg  = pan_r;
  assign out_tilt_centideg = tilt_r;

endmodule

[rtl/core/ptzp_checker.sv]
module ptzp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_frame_status,
  input logic [15:0] out_pan_centideg,
  input logic [15:0] out_tilt_centideg
);

  logic [15:0] prev_pan_r;
  logic [15:0] prev_tilt_r;
  logic        out_acc;

  assign out_acc = out_valid && !out_stall;

  // Positions carried by the last delivered item; both stores start at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pan_r  <= '0;
      prev_tilt_r <= '0;
    end else if (out_acc) begin
      prev_pan_r  <= out_pan_centideg;
      prev_tilt_r <= out_tilt_centideg;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_status) &&
      $stable(out_pan_centideg) && $stable(out_tilt_centideg))
    else $error("stalled result changed");

  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status == ptzp_pkg::ST_OTHER ||
      out_frame_status == ptzp_pkg::ST_BADSUM) |->
      out_pan_centideg == prev_pan_r && out_tilt_centideg == prev_tilt_r)
    else $error("position changed without an update frame");

  a_pan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ptzp_pkg::ST_PAN |->
      out_tilt_centideg == prev_tilt_r)
    else $error("pan frame changed tilt");

  a_tilt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ptzp_pkg::ST_TILT |->
      out_pan_centideg == prev_pan_r)
    else $error("tilt frame changed pan");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

endmodule

bind ptz_position_reply_parser ptzp_checker u_ptzp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_frame_status  (out_frame_status),
  .out_pan_centideg  (out_pan_centideg),
  .out_tilt_centideg (out_tilt_centideg)
);

[sim/tb_ptz_position_reply_parser.sv]
`timescale 1ns / 100ps

module tb_ptz_position_reply_parser;

  typedef struct {
    logic [7:0] rx;
    bit         drain_first;
  } rx_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] pan;
    logic [15:0] tilt;
  } reply_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALT, STALL_BLOCK} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_frame_status;
  logic [15:0] out_pan_centideg;
  logic [15:0] out_tilt_centideg;

  rx_item_t    rx_queue[$];
  reply_t      reply_queue[$];
  int          mismatch_count = 0;
  int          status_seen[4] = '{0, 0, 0, 0};
  int          bytes_taken = 0;
  bit          byte_taken = 1'b0;
  int          burst_left = 8;
  int          gap_left = 0;
  int          rx_cycle = 0;
  stall_mode_t stall_mode = STALL_NONE;

  // Shadow of the parser state.
  logic [15:0] sync_hist;
  bit          in_body;
  logic [1:0]  body_pos;
  logic [7:0]  cmd_seen, data_hi, data_lo, sum_acc;
  logic [15:0] pan_pos, tilt_pos;

  ptz_position_reply_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_status  (out_frame_status),
    .out_pan_centideg  (out_pan_centideg),
    .out_tilt_centideg (out_tilt_centideg)
  );

  always #5 clk = ~clk;

  task automatic parse_reply_byte(input logic [7:0] b);
    reply_t r;
    if (!in_body) begin
      if (sync_hist == {ptzp_pkg::SYNC_B0, ptzp_pkg::SYNC_B1} && b == ptzp_pkg::SYNC_B2) begin
        in_body   = 1'b1;
        body_pos  = ptzp_pkg::BODY_CMD;
        sum_acc   = ptzp_pkg::SYNC_B1 + ptzp_pkg::SYNC_B2;
        sync_hist = 16'h0000;
      end else begin
        sync_hist = {sync_hist[7:0], b};
      end
    end else if (body_pos != ptzp_pkg::BODY_SUM) begin
      case (body_pos)
        ptzp_pkg::BODY_CMD: cmd_seen = b;
        ptzp_pkg::BODY_DH:  data_hi = b;
        default:            data_lo = b;
      endcase
      sum_acc  = sum_acc + b;
      body_pos = body_pos + 2'd1;
    end else begin
      if (b != sum_acc) begin
        r.status = ptzp_pkg::ST_BADSUM;
      end else if (cmd_seen == ptzp_pkg::CMD_PAN) begin
        pan_pos  = {data_hi, data_lo};
        r.status = ptzp_pkg::ST_PAN;
      end else if (cmd_seen == ptzp_pkg::CMD_TILT) begin
        tilt_pos = {data_hi, data_lo};
        r.status = ptzp_pkg::ST_TILT;
      end else begin
        r.status = ptzp_pkg::ST_OTHER;
      end
      r.pan     = pan_pos;
      r.tilt    = tilt_pos;
      in_body   = 1'b0;
      body_pos  = ptzp_pkg::BODY_CMD;
      sync_hist = 16'h0000;
      reply_queue.push_back(r);
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input bit drain_first = 1'b0);
    rx_item_t it;
    it.rx          = b;
    it.drain_first = drain_first;
    rx_queue.push_back(it);
  endtask

  // A full frame; a bad frame gets its checksum disturbed by a nonzero amount.
  task automatic add_frame(input logic [7:0] cmd, input logic [15:0] data, input bit bad,
                           input bit drain_first = 1'b0);
    logic [7:0] cs;
    cs = ptzp_pkg::SYNC_B1 + ptzp_pkg::SYNC_B2 + cmd + data[15:8] + data[7:0];
    if (bad) cs = cs + 8'($urandom_range(1, 255));
    add_byte(ptzp_pkg::SYNC_B0, drain_first);
    add_byte(ptzp_pkg::SYNC_B1);
    add_byte(ptzp_pkg::SYNC_B2);
    add_byte(cmd);
    add_byte(data[15:8]);
    add_byte(data[7:0]);
    add_byte(cs);
  endtask

  // Random byte that leans toward the sync values.
  function automatic logic [7:0] sync_biased_byte();
    case ($urandom_range(0, 7))
      0: return ptzp_pkg::SYNC_B0;
      1: return ptzp_pkg::SYNC_B1;
      2: return ptzp_pkg::SYNC_B2;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_position();
    case ($urandom_range(0, 7))
      0: return 16'hFFFF;
      1: return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Driver: holds an item until it is taken, then offers the next one in bursts.
  always @(negedge clk) begin : drive_proc
    rx_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !byte_taken) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (rx_queue.size() == 0) begin
      in_valid <= 1'b0;
    end else if (rx_queue[0].drain_first && reply_queue.size() != 0) begin
      in_valid <= 1'b0;
    end else begin
      it = rx_queue.pop_front();
      in_valid   <= 1'b1;
      in_rx_byte <= it.rx;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Receiver: a stall pattern that changes now and then, plus a long hold-off
  // that lets the block fill up and push back on its input.
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 700 == 0) stall_mode <= stall_mode_t'($urandom_range(0, 4));
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_cycle % 3000 >= 600 && rx_cycle % 3000 < 900) begin
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        STALL_ALT:   out_stall <= rx_cycle[0];
        default:     out_stall <= rx_cycle[3];
      endcase
    end
  end

  // Accepted bytes feed the shadow parser; accepted results are checked in order.
  always @(posedge clk) begin : monitor_proc
    reply_t exp_r;
    byte_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      parse_reply_byte(in_rx_byte);
      bytes_taken <= bytes_taken + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (reply_queue.size() == 0) begin
        $display("%0t: unexpected result status=%0d pan=%h tilt=%h", $time,
                 out_frame_status, out_pan_centideg, out_tilt_centideg);
        mismatch_count <= mismatch_count + 1;
      end else begin
        exp_r = reply_queue.pop_front();
        status_seen[exp_r.status] <= status_seen[exp_r.status] + 1;
        if (out_frame_status !== exp_r.status || out_pan_centideg !== exp_r.pan ||
            out_tilt_centideg !== exp_r.tilt) begin
          $display("%0t: expected status=%0d pan=%h tilt=%h, got status=%0d pan=%h tilt=%h",
                   $time, exp_r.status, exp_r.pan, exp_r.tilt,
                   out_frame_status, out_pan_centideg, out_tilt_centideg);
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  initial begin
    int kind;
    int n;
    bit drain_a;
    bit drain_b;
    logic [7:0] cmd;

    sync_hist = 16'h0000;
    in_body   = 1'b0;
    body_pos  = ptzp_pkg::BODY_CMD;
    cmd_seen  = 8'h00;
    data_hi   = 8'h00;
    data_lo   = 8'h00;
    sum_acc   = 8'h00;
    pan_pos   = 16'h0000;
    tilt_pos  = 16'h0000;
    drain_a   = 1'b0;
    drain_b   = 1'b0;

    // Directed: noise, an overlapping sync, both commands at extreme data, another command, a bad checksum.
    add_byte(8'h00);
    add_byte(ptzp_pkg::SYNC_B0);
    add_byte(ptzp_pkg::SYNC_B1);
    add_byte(ptzp_pkg::SYNC_B0);
    add_frame(ptzp_pkg::CMD_PAN, 16'hFFFF, 1'b0);
    add_frame(ptzp_pkg::CMD_TILT, 16'h8001, 1'b0);
    add_frame(8'hA6, 16'h7FFE, 1'b0);
    add_frame(ptzp_pkg::CMD_PAN, 16'h0000, 1'b1);

    while (rx_queue.size() < 920) begin
      kind = $urandom_range(0, 19);
      if (!drain_a && rx_queue.size() >= 300) begin
        drain_a = 1'b1;
        add_frame(ptzp_pkg::CMD_TILT, pick_position(), 1'b0, 1'b1);
      end else if (!drain_b && rx_queue.size() >= 650) begin
        drain_b = 1'b1;
        add_frame(ptzp_pkg::CMD_PAN, pick_position(), 1'b0, 1'b1);
      end else if (kind < 11) begin
        n = $urandom_range(0, 9);
        cmd = (n < 4) ? ptzp_pkg::CMD_PAN : (n < 7) ? ptzp_pkg::CMD_TILT :
              8'($urandom_range(0, 255));
        add_frame(cmd, pick_position(), 1'b0);
      end else if (kind < 13) begin
        add_frame((kind == 11) ? ptzp_pkg::CMD_PAN : ptzp_pkg::CMD_TILT, pick_position(),
                  1'b1);
      end else if (kind < 15) begin
        // Body bytes that look like a sync must not restart the frame.
        add_frame(sync_biased_byte(), {sync_biased_byte(), sync_biased_byte()},
                  ($urandom_range(0, 3) == 0));
      end else if (kind < 17) begin
        n = $urandom_range(1, 6);
        repeat (n) add_byte(sync_biased_byte());
      end else if (kind == 17) begin
        add_byte(ptzp_pkg::SYNC_B0);
        add_byte(ptzp_pkg::SYNC_B1);
        add_byte(8'($urandom_range(1, 255)));
      end else begin
        // Truncated frame: whatever follows is taken as its body.
        add_byte(ptzp_pkg::SYNC_B0);
        add_byte(ptzp_pkg::SYNC_B1);
        add_byte(ptzp_pkg::SYNC_B2);
        n = $urandom_range(0, 3);
        repeat (n) add_byte(sync_biased_byte());
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    do @(posedge clk);
    while (rx_queue.size() != 0 || in_valid || reply_queue.size() != 0);
    repeat (10) @(posedge clk);

    $display("Run took %0d bytes; frames seen: %0d pan, %0d tilt, %0d other, %0d bad checksum.",
             bytes_taken, status_seen[ptzp_pkg::ST_PAN], status_seen[ptzp_pkg::ST_TILT],
             status_seen[ptzp_pkg::ST_OTHER], status_seen[ptzp_pkg::ST_BADSUM]);
    $display("Receiver stall patterns and long hold-offs were mixed with sender bursts and gaps.");
    if (mismatch_count == 0 && reply_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results still expected", reply_queue.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
